// ----- src/abs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package abs_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int CMDQ_DEPTH        = 2;

    localparam int DATA_W  = 64;
    localparam int CHECK_W = 12;
    localparam int TIME_W  = 16;
    localparam int ACT_W   = 2;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 88;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd20;

    localparam logic [ACT_W-1:0] ACT_MSG  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

    typedef enum logic [1:0] {
        CMD_MSG,
        CMD_ACK,
        CMD_TICK,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [DATA_W-1:0]          payload;
        logic signed [CHECK_W-1:0]  sum;
        logic                       ack_ok;
        logic                       ack_num;
    } cmd_t;

    typedef struct packed {
        logic                       send_valid;
        logic                       pkt_seq;
        logic signed [CHECK_W-1:0]  pkt_check;
        logic [DATA_W-1:0]          pkt_payload;
        logic                       msg_queued;
        logic                       msg_dropped;
        logic                       ack_taken;
        logic                       busy_res;
    } res_t;

    function automatic logic [DATA_W-1:0] payload_trim(input logic [DATA_W-1:0] v,
                                                       input int nbytes);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int i = 0; i < DATA_W / 8; i++)
        begin
            if (i < nbytes)
            begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic signed [CHECK_W-1:0] byte_sum(input logic [DATA_W-1:0] v,
                                                           input int nbytes);
        logic signed [CHECK_W-1:0] s;
        logic [7:0]                b;
        s = '0;
        for (int i = 0; i < DATA_W / 8; i++)
        begin
            b = v[8*i +: 8];
            if (i < nbytes)
            begin
                s = s + $signed({{(CHECK_W-8){b[7]}}, b});
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- src/abs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module abs_front #(
    parameter int PAYLOAD_BYTES = abs_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic [abs_pkg::ACT_W-1:0]      action,
    input  wire logic [abs_pkg::IN_TDATA_W-1:0] word,
    output abs_pkg::cmd_t                       cmd
);
    import abs_pkg::*;

    logic [DATA_W-1:0]         msg_data;
    logic                      ack_seq;
    logic                      ack_num;
    logic signed [CHECK_W-1:0] ack_check;
    logic [DATA_W-1:0]         ack_payload;
    logic signed [CHECK_W-1:0] ack_calc;

    assign msg_data    = word[63:0];
    assign ack_seq     = word[64];
    assign ack_num     = word[65];
    assign ack_check   = $signed(word[77:66]);
    assign ack_payload = word[141:78];

    assign ack_calc = byte_sum(ack_payload, PAYLOAD_BYTES)
                    + $signed({{(CHECK_W-1){1'b0}}, ack_seq})
                    + $signed({{(CHECK_W-1){1'b0}}, ack_num});

    always_comb
    begin
        cmd         = '0;
        cmd.kind    = CMD_NOP;
        cmd.ack_num = ack_num;
        case (action)
            ACT_MSG:
            begin
                cmd.kind    = CMD_MSG;
                cmd.payload = payload_trim(msg_data, PAYLOAD_BYTES);
                cmd.sum     = byte_sum(msg_data, PAYLOAD_BYTES);
            end
            ACT_ACK:
            begin
                cmd.kind   = CMD_ACK;
                cmd.ack_ok = (ack_calc == ack_check);
            end
            ACT_TICK:
            begin
                cmd.kind = CMD_TICK;
            end
            default:
            begin
                cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/abs_cmdq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module abs_cmdq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire abs_pkg::cmd_t push_cmd,
    output logic               push_ready,
    output logic               pop_valid,
    output abs_pkg::cmd_t      pop_cmd,
    input  wire logic          pop
);
    import abs_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          slot_reg [CMDQ_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (cnt_reg != CW'(CMDQ_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // hold payload, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/abs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module abs_back #(
    parameter int QUEUE_DEPTH = abs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [abs_pkg::TIME_W-1:0] timeout,
    input  wire logic                       cmd_valid,
    input  wire abs_pkg::cmd_t              cmd,
    output logic                            cmd_pop,
    output logic                            out_valid,
    output abs_pkg::res_t                   out_res,
    input  wire logic                       out_ready
);
    import abs_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [DATA_W-1:0]         payload;
        logic signed [CHECK_W-1:0] sum;
    } qent_t;

    qent_t                     mem [QUEUE_DEPTH];
    qent_t                     head_reg;
    qent_t                     wr_ent;

    logic                      seq_reg, seq_next;
    logic                      wait_reg, wait_next;
    logic [DATA_W-1:0]         held_reg, held_next;
    logic signed [CHECK_W-1:0] hsum_reg, hsum_next;
    logic [TIME_W-1:0]         tick_reg, tick_next;
    logic [QW-1:0]             qhead_reg, qhead_next;
    logic [QW-1:0]             qtail_reg, qtail_next;
    logic [CW-1:0]             fill_reg, fill_next;
    logic                      ovalid_reg, ovalid_next;
    res_t                      res_reg, res_next;

    logic                      step;
    logic                      q_push;
    logic                      q_pop;
    logic                      emit;
    logic [DATA_W-1:0]         emit_payload;
    logic signed [CHECK_W-1:0] emit_sum;
    logic [TIME_W-1:0]         limit;
    logic [TIME_W:0]           tick_inc;

    function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
        if (p == QW'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign step      = cmd_valid && (!ovalid_reg || out_ready);
    assign cmd_pop   = step;
    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;

    assign limit    = (timeout == '0) ? TIME_W'(1) : timeout;
    assign tick_inc = {1'b0, tick_reg} + (TIME_W + 1)'(1);
    assign wr_ent   = '{payload: cmd.payload, sum: cmd.sum};

    always_comb
    begin
        seq_next     = seq_reg;
        wait_next    = wait_reg;
        held_next    = held_reg;
        hsum_next    = hsum_reg;
        tick_next    = tick_reg;
        fill_next    = fill_reg;
        q_push       = 1'b0;
        q_pop        = 1'b0;
        emit         = 1'b0;
        emit_payload = held_reg;
        emit_sum     = hsum_reg;
        res_next     = '0;

        if (step)
        begin
            case (cmd.kind)
                CMD_MSG:
                begin
                    if (!wait_reg)
                    begin
                        emit         = 1'b1;
                        emit_payload = cmd.payload;
                        emit_sum     = cmd.sum;
                    end
                    else if (fill_reg < CW'(QUEUE_DEPTH))
                    begin
                        q_push              = 1'b1;
                        fill_next           = fill_reg + 1'b1;
                        res_next.msg_queued = 1'b1;
                    end
                    else
                    begin
                        res_next.msg_dropped = 1'b1;
                    end
                end
                CMD_ACK:
                begin
                    if (wait_reg && cmd.ack_ok && (cmd.ack_num == seq_reg))
                    begin
                        res_next.ack_taken = 1'b1;
                        seq_next           = ~seq_reg;
                        wait_next          = 1'b0;
                        tick_next          = '0;
                        if (fill_reg != '0)
                        begin
                            q_pop        = 1'b1;
                            fill_next    = fill_reg - 1'b1;
                            emit         = 1'b1;
                            emit_payload = head_reg.payload;
                            emit_sum     = head_reg.sum;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (wait_reg)
                    begin
                        tick_next = tick_inc[TIME_W-1:0];
                        if (tick_inc >= {1'b0, limit})
                        begin
                            emit = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (emit)
        begin
            res_next.send_valid  = 1'b1;
            res_next.pkt_seq     = seq_next;
            res_next.pkt_check   = emit_sum + $signed({{(CHECK_W-1){1'b0}}, seq_next});
            res_next.pkt_payload = emit_payload;
            held_next            = emit_payload;
            hsum_next            = emit_sum;
            wait_next            = 1'b1;
            tick_next            = '0;
        end
        res_next.busy_res = wait_next;

        qtail_next = q_push ? ptr_inc(qtail_reg) : qtail_reg;
        qhead_next = q_pop  ? ptr_inc(qhead_reg) : qhead_reg;

        if (step)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= 1'b0;
            wait_reg   <= 1'b0;
            held_reg   <= '0;
            hsum_reg   <= '0;
            tick_reg   <= '0;
            qhead_reg  <= '0;
            qtail_reg  <= '0;
            fill_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            seq_reg    <= seq_next;
            wait_reg   <= wait_next;
            held_reg   <= held_next;
            hsum_reg   <= hsum_next;
            tick_reg   <= tick_next;
            qhead_reg  <= qhead_next;
            qtail_reg  <= qtail_next;
            fill_reg   <= fill_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    // message queue; prefetch the next head entry, bypass a same-cycle write
    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            mem[qtail_reg] <= wr_ent;
        end
        if (q_push && (qtail_reg == qhead_next))
        begin
            head_reg <= wr_ent;
        end
        else
        begin
            head_reg <= mem[qhead_next];
        end
    end

endmodule

`default_nettype wire

// ----- src/alternating_bit_sender.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake             Payload
// s_*       in   s_tvalid / s_tready   s_tuser action, s_tdata message and ack fields
// m_*       out  m_tvalid / m_tready   m_tdata packet and status flags
// cfg_*     in   cfg_valid / cfg_ready cfg_data timeout_ticks
//
// One word per cycle in and out while s_tready and m_tready stay high. A taken word
// passes the command queue and then the output register before it is on m_tdata.
// Reset clears sequence state, queue pointers and sets timeout_ticks to 20;
// message queue entries are not cleared.
// m_tready low holds the output register; the two-entry command queue keeps
// s_tready high until it fills.
module alternating_bit_sender #(
    parameter int PAYLOAD_BYTES = abs_pkg::PAYLOAD_BYTES_DEF,
    parameter int QUEUE_DEPTH   = abs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [63:0] message_data, [64] ack_seqnum, [65] ack_number,
    // [77:66] ack_check, [141:78] ack_payload, [143:142] zero
    input  wire logic [abs_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [1:0] action
    input  wire logic [abs_pkg::ACT_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] send_valid, [1] pkt_seq, [13:2] pkt_check, [77:14] pkt_payload,
    // [78] msg_queued, [79] msg_dropped, [80] ack_taken, [81] busy_res, [87:82] zero
    output logic [abs_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [abs_pkg::TIME_W-1:0]      cfg_data
);
    import abs_pkg::*;

    logic [TIME_W-1:0] timeout_reg;
    cmd_t              front_cmd;
    cmd_t              q_cmd;
    logic              q_valid;
    logic              q_pop;
    res_t              res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            timeout_reg <= cfg_data;
        end
    end

    abs_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .action (s_tuser),
        .word   (s_tdata),
        .cmd    (front_cmd)
    );

    abs_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_cmd   (front_cmd),
        .push_ready (s_tready),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd),
        .pop        (q_pop)
    );

    abs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .timeout   (timeout_reg),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_res   (res),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'b0, res.busy_res, res.ack_taken, res.msg_dropped, res.msg_queued,
                      res.pkt_payload, res.pkt_check, res.pkt_seq, res.send_valid};

    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.send_valid |-> res.busy_res)
        else $error("sent packet without busy flag");

    a_queued_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.msg_queued |-> !res.send_valid && !res.msg_dropped && !res.ack_taken)
        else $error("queued word carries other events");

    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_pop |=> m_tvalid)
        else $error("back step produced no word");

    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> q_valid)
        else $error("accepted word missing from command queue");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import abs_pkg::*;

    localparam int NBYTES         = PAYLOAD_BYTES_DEF;
    localparam int QDEPTH         = QUEUE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 325;
    localparam int PHASES         = 6;
    localparam int SETTLE_CYCLES  = 4;

    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]   act;
        logic [DATA_W-1:0]  msg;
        logic               aseq;
        logic               anum;
        logic [CHECK_W-1:0] achk;
        logic [DATA_W-1:0]  apay;
    } abp_event_t;

    typedef struct {
        abp_event_t ev;
        bit         typed;
        res_t       want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [TIME_W-1:0]      cfg_data;

    // sender state as predicted
    logic               p_seq     = 1'b0;
    logic               p_wait    = 1'b0;
    logic [DATA_W-1:0]  p_held    = '0;
    int                 p_ticks   = 0;
    logic [TIME_W-1:0]  p_timeout = TIMEOUT_RESET;
    logic [DATA_W-1:0]  p_fifo[$];

    res_t               sent_reports[$];
    dir_row_t           dir_rows[$];
    logic [TIME_W-1:0]  phase_timeouts[PHASES] = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd7, 16'd2};

    int  mismatches  = 0;
    int  quiet_cycles = 0;
    int  rdy_hold    = 0;
    bit  calm        = 1'b0;

    alternating_bit_sender u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] trim_bytes(input logic [DATA_W-1:0] v);
        for (int i = 0; i < DATA_W / 8; i++)
        begin
            if (i >= NBYTES)
            begin
                v[8*i +: 8] = 8'h00;
            end
        end
        return v;
    endfunction

    function automatic int signed_byte_total(input logic [DATA_W-1:0] v);
        int s;
        int b;
        s = 0;
        for (int i = 0; i < NBYTES && i < DATA_W / 8; i++)
        begin
            b = int'($signed(v[8*i +: 8]));
            s += b;
        end
        return s;
    endfunction

    function automatic abp_event_t mk_ev(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] msg,
                                         input logic aseq, input logic anum,
                                         input logic [CHECK_W-1:0] achk,
                                         input logic [DATA_W-1:0] apay);
        abp_event_t ev;
        ev.act  = act;
        ev.msg  = msg;
        ev.aseq = aseq;
        ev.anum = anum;
        ev.achk = achk;
        ev.apay = apay;
        return ev;
    endfunction

    function automatic res_t mk_res(input logic send, input logic seq,
                                    input logic [CHECK_W-1:0] chk, input logic [DATA_W-1:0] pay,
                                    input logic queued, input logic dropped,
                                    input logic taken, input logic busy);
        res_t r;
        r.send_valid  = send;
        r.pkt_seq     = seq;
        r.pkt_check   = chk;
        r.pkt_payload = pay;
        r.msg_queued  = queued;
        r.msg_dropped = dropped;
        r.ack_taken   = taken;
        r.busy_res    = busy;
        return r;
    endfunction

    task automatic add_row(input abp_event_t ev, input bit typed, input res_t want);
        dir_row_t row;
        row.ev    = ev;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic send_packet(inout res_t r, input logic [DATA_W-1:0] pay);
        int c;
        c = int'(p_seq) + signed_byte_total(pay);
        r.send_valid  = 1'b1;
        r.pkt_seq     = p_seq;
        r.pkt_check   = CHECK_W'(c);
        r.pkt_payload = pay;
        p_held  = pay;
        p_wait  = 1'b1;
        p_ticks = 0;
    endtask

    task automatic sender_step(input abp_event_t ev, output res_t r);
        int chk;
        int calc;
        int lim;
        r = '0;
        case (ev.act)
            ACT_MSG:
            begin
                if (!p_wait)
                begin
                    send_packet(r, trim_bytes(ev.msg));
                end
                else if (p_fifo.size() < QDEPTH)
                begin
                    p_fifo.push_back(trim_bytes(ev.msg));
                    r.msg_queued = 1'b1;
                end
                else
                begin
                    r.msg_dropped = 1'b1;
                end
            end
            ACT_ACK:
            begin
                if (p_wait)
                begin
                    chk  = int'($signed(ev.achk));
                    calc = int'(ev.aseq) + int'(ev.anum) + signed_byte_total(trim_bytes(ev.apay));
                    if (chk == calc && ev.anum == p_seq)
                    begin
                        r.ack_taken = 1'b1;
                        p_seq   = ~p_seq;
                        p_wait  = 1'b0;
                        p_ticks = 0;
                        if (p_fifo.size() > 0)
                        begin
                            send_packet(r, p_fifo.pop_front());
                        end
                    end
                end
            end
            ACT_TICK:
            begin
                if (p_wait)
                begin
                    lim = (p_timeout == 0) ? 1 : int'(p_timeout);
                    p_ticks++;
                    if (p_ticks >= lim)
                    begin
                        send_packet(r, p_held);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.busy_res = p_wait;
    endtask

    function automatic logic [DATA_W-1:0] rand_payload();
        logic [DATA_W-1:0] v;
        logic [7:0]        pick[4];
        pick = '{8'h80, 8'h7F, 8'hFF, 8'h00};
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:
            begin
                for (int i = 0; i < DATA_W / 8; i++)
                begin
                    v[8*i +: 8] = pick[$urandom_range(0, 3)];
                end
            end
            1:
            begin
                v = {(DATA_W / 8){pick[$urandom_range(0, 3)]}};
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    function automatic abp_event_t pick_event();
        abp_event_t ev;
        int sel;
        int calc;
        ev  = mk_ev(ACT_TICK, rand_payload(), 1'($urandom), 1'($urandom),
                    CHECK_W'($urandom), rand_payload());
        sel = $urandom_range(0, 99);
        if (sel < 36)
        begin
            ev.act = ACT_MSG;
        end
        else if (sel < 70)
        begin
            ev.act = ACT_ACK;
            if (p_wait && $urandom_range(0, 99) < 80)
            begin
                ev.anum = p_seq;
            end
            calc    = int'(ev.aseq) + int'(ev.anum) + signed_byte_total(trim_bytes(ev.apay));
            ev.achk = CHECK_W'(calc);
            // break some acks: wrong bit, off checksum or random checksum
            if (!p_wait || ev.anum != p_seq || $urandom_range(0, 99) < 10)
            begin
                case ($urandom_range(0, 3))
                    0: ev.anum = ~p_seq;
                    1: ev.achk = CHECK_W'(calc + int'($urandom_range(1, 9)));
                    2: ev.achk = CHECK_W'($urandom_range(0, 4095));
                    default: ;
                endcase
            end
        end
        else if (sel < 96)
        begin
            ev.act = ACT_TICK;
        end
        else
        begin
            ev.act = ACT_SPARE;
        end
        return ev;
    endfunction

    task automatic push_event(input abp_event_t ev, input bit typed, input res_t want);
        res_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ev.apay, ev.achk, ev.anum, ev.aseq, ev.msg};
        s_tuser  <= ev.act;
        do
            @(posedge clk);
        while (!s_tready);
        sender_step(ev, r);
        sent_reports.push_back(typed ? want : r);
    endtask

    task automatic sender_pause(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_all();
        sender_pause(1);
        while (sent_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [TIME_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        p_timeout = v;
    endtask

    task automatic compare_field(input string tag, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t %s expected %h actual %h", $time, tag, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.send_valid  = m_tdata[0];
            got.pkt_seq     = m_tdata[1];
            got.pkt_check   = m_tdata[13:2];
            got.pkt_payload = m_tdata[77:14];
            got.msg_queued  = m_tdata[78];
            got.msg_dropped = m_tdata[79];
            got.ack_taken   = m_tdata[80];
            got.busy_res    = m_tdata[81];
            if (sent_reports.size() == 0)
            begin
                $display("%0t unexpected word expected none actual %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = sent_reports.pop_front();
                compare_field("send_valid", DATA_W'(want.send_valid), DATA_W'(got.send_valid));
                compare_field("pkt_seq", DATA_W'(want.pkt_seq), DATA_W'(got.pkt_seq));
                compare_field("pkt_check", DATA_W'(want.pkt_check), DATA_W'(got.pkt_check));
                compare_field("pkt_payload", want.pkt_payload, got.pkt_payload);
                compare_field("msg_queued", DATA_W'(want.msg_queued), DATA_W'(got.msg_queued));
                compare_field("msg_dropped", DATA_W'(want.msg_dropped),
                              DATA_W'(got.msg_dropped));
                compare_field("ack_taken", DATA_W'(want.ack_taken), DATA_W'(got.ack_taken));
                compare_field("busy_res", DATA_W'(want.busy_res), DATA_W'(got.busy_res));
            end
        end
    end

    // receiver stalls in bursts, none once calm
    always @(posedge clk)
    begin
        if (rdy_hold > 0)
        begin
            rdy_hold--;
        end
        else if (calm || !m_tready)
        begin
            m_tready <= 1'b1;
            rdy_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 15);
        end
        else
        begin
            m_tready <= 1'b0;
            rdy_hold = $urandom_range(0, 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        abp_event_t ev;
        res_t       none;
        int         done;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        none      = '0;

        add_row(mk_ev(ACT_ACK, '0, 1'b0, 1'b0, 12'h000, '0), 1'b1, none);
        add_row(mk_ev(ACT_TICK, '0, 1'b0, 1'b0, 12'h000, '0), 1'b1, none);
        add_row(mk_ev(ACT_SPARE, '1, 1'b1, 1'b1, 12'hFFF, '1), 1'b1, none);
        add_row(mk_ev(ACT_MSG, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b1, 1'b0, 12'hFF8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_MSG, 64'h7F7F_7F7F_7F7F_7F7F, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_MSG, 64'h8080_8080_8080_8080, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_MSG, 64'h0000_0000_0000_0000, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_MSG, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_MSG, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_MSG, 64'h55AA_55AA_55AA_55AA, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_MSG, 64'hAA55_AA55_AA55_AA55, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_MSG, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_MSG, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b1));
        add_row(mk_ev(ACT_SPARE, '0, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_ACK, '0, 1'b0, 1'b0, 12'h7FF, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_ACK, '0, 1'b1, 1'b0, 12'h800, '1), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_ACK, '0, 1'b0, 1'b1, 12'h001, '0), 1'b1,
                mk_res(1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(mk_ev(ACT_ACK, '0, 1'b0, 1'b0, 12'h000, '0), 1'b1,
                mk_res(1'b1, 1'b1, 12'd1017, 64'h7F7F_7F7F_7F7F_7F7F, 1'b0, 1'b0, 1'b1, 1'b1));
        add_row(mk_ev(ACT_ACK, '0, 1'b1, 1'b1, 12'hC02, 64'h8080_8080_8080_8080), 1'b1,
                mk_res(1'b1, 1'b0, 12'hC00, 64'h8080_8080_8080_8080, 1'b0, 1'b0, 1'b1, 1'b1));
        add_row(mk_ev(ACT_TICK, '0, 1'b0, 1'b0, 12'h000, '0), 1'b0, none);
        add_row(mk_ev(ACT_TICK, '1, 1'b1, 1'b1, 12'hFFF, '1), 1'b0, none);
        add_row(mk_ev(ACT_TICK, '0, 1'b0, 1'b0, 12'h000, '0), 1'b0, none);
        add_row(mk_ev(ACT_ACK, '0, 1'b1, 1'b0,
                      CHECK_W'(1 + signed_byte_total(64'hFEDC_BA98_7654_3210)),
                      64'hFEDC_BA98_7654_3210), 1'b0, none);
        add_row(mk_ev(ACT_MSG, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 12'h000, '0), 1'b0, none);
        add_row(mk_ev(ACT_ACK, '0, 1'b0, 1'b1, 12'h001, 64'h0000_0000_0000_0100), 1'b0, none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            push_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
            if ($urandom_range(0, 3) == 0)
            begin
                sender_pause($urandom_range(1, 8));
            end
        end
        drain_all();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            calm = (ph == PHASES - 1);
            set_timeout(phase_timeouts[ph]);
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                ev = pick_event();
                if (ev.act == ACT_MSG || p_wait)
                begin
                    done++;
                end
                push_event(ev, 1'b0, none);
                if (!calm && $urandom_range(0, 3) == 0)
                begin
                    sender_pause($urandom_range(1, 8));
                end
            end
            drain_all();
        end

        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
